// ===== hw/rtl/kce_pkg.sv =====
package kce_pkg;

  // Depth of the entry buffer in keys.
  localparam int unsigned BUFFER_DEPTH = 10;

  // Field widths.
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned STOP_W  = 2;
  localparam int unsigned VALUE_W = 30;

  // Request types.
  localparam logic REQ_KEY   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Key codes.
  localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
  localparam logic [KEY_W-1:0] KEY_STAR  = 4'd10;
  localparam logic [KEY_W-1:0] KEY_ZERO  = 4'd11;
  localparam logic [KEY_W-1:0] KEY_HASH  = 4'd12;

  // First terminator codes.
  localparam logic [STOP_W-1:0] STOP_NONE = 2'd0;
  localparam logic [STOP_W-1:0] STOP_STAR = 2'd1;
  localparam logic [STOP_W-1:0] STOP_HASH = 2'd2;
  localparam logic [STOP_W-1:0] STOP_FULL = 2'd3;

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(BUFFER_DEPTH);

  // One captured input transaction.
  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key_code;
  } item_t;

  // Running totals of the entry buffer.
  typedef struct packed {
    logic [COUNT_W-1:0] fill;
    logic [STOP_W-1:0]  stop;
    logic [COUNT_W-1:0] digits;
    logic [VALUE_W-1:0] value;
  } totals_t;

endpackage

// ===== hw/rtl/kce_in_stage.sv =====
module kce_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [kce_pkg::KEY_W-1:0] in_key_code,
  input  logic                      advance_i,
  output logic                      item_valid_o,
  output kce_pkg::item_t            item_o
);

  logic           valid_r;
  logic           valid_nxt;
  kce_pkg::item_t item_r;

  // The stage takes a new transaction when empty or when its item moves on.
  assign in_ready  = !valid_r || advance_i;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance_i ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req_type <= in_req_type;
      item_r.key_code <= in_key_code;
    end
  end

  assign item_valid_o = valid_r;
  assign item_o       = item_r;

endmodule

// ===== hw/rtl/kce_update.sv =====
module kce_update (
  input  kce_pkg::item_t   item_i,
  input  kce_pkg::totals_t cur_i,
  output kce_pkg::totals_t nxt_o,
  output logic             overflow_o
);

  logic                          key_valid;
  logic [kce_pkg::COUNT_W-1:0]   fill_inc;
  logic [kce_pkg::VALUE_W-1:0]   digit_val;
  logic [kce_pkg::VALUE_W-1:0]   value_x10;

  assign key_valid = (item_i.key_code != kce_pkg::KEY_NONE) &&
                     (item_i.key_code <= kce_pkg::KEY_HASH);
  assign fill_inc  = cur_i.fill + kce_pkg::COUNT_W'(1);
  assign digit_val = (item_i.key_code == kce_pkg::KEY_ZERO) ? '0 :
                     kce_pkg::VALUE_W'(item_i.key_code);
  // Times ten as two shifts and an add; the result wraps at the field width.
  assign value_x10 = (cur_i.value << 3) + (cur_i.value << 1);

  always_comb begin
    nxt_o      = cur_i;
    overflow_o = 1'b0;
    if (item_i.req_type == kce_pkg::REQ_CLEAR) begin
      nxt_o = '0;
    end else if (key_valid) begin
      if (cur_i.fill >= kce_pkg::DEPTH_CNT) begin
        // A key on a full buffer is dropped and the buffer emptied.
        nxt_o      = '0;
        overflow_o = 1'b1;
      end else begin
        nxt_o.fill = fill_inc;
        if (cur_i.stop == kce_pkg::STOP_NONE) begin
          if (item_i.key_code == kce_pkg::KEY_STAR) begin
            nxt_o.stop = kce_pkg::STOP_STAR;
          end else if (item_i.key_code == kce_pkg::KEY_HASH) begin
            nxt_o.stop = kce_pkg::STOP_HASH;
          end else if (fill_inc >= kce_pkg::DEPTH_CNT) begin
            // The last free slot took a digit with no terminator seen.
            nxt_o.stop   = kce_pkg::STOP_FULL;
            nxt_o.digits = fill_inc;
            nxt_o.value  = '0;
          end else begin
            nxt_o.digits = cur_i.digits + kce_pkg::COUNT_W'(1);
            nxt_o.value  = value_x10 + digit_val;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/keypad_code_entry_core.sv =====
// Keypad code entry core. Each key-press or clear transaction produces one
// result transaction carrying the overflow flag, the number of keys held,
// the first terminator, the digit count before it and their decimal value.
// The block accepts one transaction per clock cycle when its results are
// not stalled. A result passes through the input register and the result
// register, with one pass of the running-total update logic between them.
// A stalled result holds the pipeline; the input register keeps accepting
// as long as its item can move into the result register.
module keypad_code_entry_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [kce_pkg::KEY_W-1:0]   in_key_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_overflow,
  output logic [kce_pkg::COUNT_W-1:0] out_entry_count,
  output logic [kce_pkg::STOP_W-1:0]  out_stop_kind,
  output logic [kce_pkg::COUNT_W-1:0] out_digit_count,
  output logic [kce_pkg::VALUE_W-1:0] out_typed_value
);

  logic             item_valid;
  kce_pkg::item_t   item;
  logic             advance;
  kce_pkg::totals_t totals_r;
  kce_pkg::totals_t totals_nxt;
  logic             overflow;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             overflow_r;
  kce_pkg::totals_t result_r;

  // The captured item moves on when the result register is free.
  assign advance = item_valid && (!out_valid_r || out_ready);

  kce_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_key_code  (in_key_code),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  kce_update u_update (
    .item_i     (item),
    .cur_i      (totals_r),
    .nxt_o      (totals_nxt),
    .overflow_o (overflow)
  );

  // Running totals advance with every item that reaches the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      totals_r <= '0;
    end else if (advance) begin
      totals_r <= totals_nxt;
    end
  end

  // Result register.
  assign out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      overflow_r <= overflow;
      result_r   <= totals_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_overflow    = overflow_r;
  assign out_entry_count = result_r.fill;
  assign out_stop_kind   = result_r.stop;
  assign out_digit_count = result_r.digits;
  assign out_typed_value = (result_r.stop == kce_pkg::STOP_FULL) ? '0 : result_r.value;

  // The buffer never holds more keys than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    totals_r.fill <= kce_pkg::DEPTH_CNT)
    else $error("fill count exceeds buffer depth");

  // Digits before the terminator never outnumber the keys held.
  a_digits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    totals_r.digits <= totals_r.fill)
    else $error("digit count exceeds fill count");

  // An overflow result reports an emptied buffer.
  a_overflow_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_entry_count == '0 && out_stop_kind == '0))
    else $error("overflow result with a non-empty buffer");

  // A buffer full of digits reports the full depth and a zero value.
  a_full_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_kind == kce_pkg::STOP_FULL) |->
      (out_digit_count == kce_pkg::DEPTH_CNT && out_entry_count == kce_pkg::DEPTH_CNT))
    else $error("full-of-digits result is inconsistent");

endmodule

// ===== tb/tb_keypad_code_entry_core.sv =====
`timescale 1ns / 100ps

module tb_keypad_code_entry_core;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned HOLD_CYCLES  = 40;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic                        overflow;
    logic [kce_pkg::COUNT_W-1:0] entry_count;
    logic [kce_pkg::STOP_W-1:0]  stop_kind;
    logic [kce_pkg::COUNT_W-1:0] digit_count;
    logic [kce_pkg::VALUE_W-1:0] typed_value;
  } entry_result_t;

  // Tracks the running totals of the entry buffer and holds the results
  // that are still to come out of the block.
  class entry_scoreboard;
    logic [kce_pkg::COUNT_W-1:0] fill;
    logic [kce_pkg::STOP_W-1:0]  stop;
    logic [kce_pkg::COUNT_W-1:0] digits;
    logic [kce_pkg::VALUE_W-1:0] value;
    entry_result_t               expected_q[$];
    int                          errors;
    int                          checked;
    int                          overflows;
    int                          full_entries;
    int                          star_stops;
    int                          hash_stops;

    function new();
      clear_totals();
      errors       = 0;
      checked      = 0;
      overflows    = 0;
      full_entries = 0;
      star_stops   = 0;
      hash_stops   = 0;
    endfunction

    function void clear_totals();
      fill   = '0;
      stop   = kce_pkg::STOP_NONE;
      digits = '0;
      value  = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted input transaction and queue the result it causes.
    function void note_input(logic req, logic [kce_pkg::KEY_W-1:0] key);
      entry_result_t               res;
      logic                        ovf;
      logic [kce_pkg::VALUE_W-1:0] digit;
      ovf = 1'b0;
      if (req == kce_pkg::REQ_CLEAR) begin
        clear_totals();
      end else if (key > kce_pkg::KEY_NONE && key <= kce_pkg::KEY_HASH) begin
        if (fill >= kce_pkg::DEPTH_CNT) begin
          // A key hitting a full buffer is dropped and the buffer emptied.
          clear_totals();
          ovf = 1'b1;
          overflows++;
        end else begin
          fill = fill + 1'b1;
          if (stop == kce_pkg::STOP_NONE) begin
            if (key == kce_pkg::KEY_STAR) begin
              stop = kce_pkg::STOP_STAR;
              star_stops++;
            end else if (key == kce_pkg::KEY_HASH) begin
              stop = kce_pkg::STOP_HASH;
              hash_stops++;
            end else if (fill >= kce_pkg::DEPTH_CNT) begin
              // The last free slot took a digit with no terminator seen.
              stop   = kce_pkg::STOP_FULL;
              digits = fill;
              value  = '0;
              full_entries++;
            end else begin
              digit  = (key == kce_pkg::KEY_ZERO) ? '0 : kce_pkg::VALUE_W'(key);
              digits = digits + 1'b1;
              value  = kce_pkg::VALUE_W'(value * 10 + digit);
            end
          end
        end
      end
      res.overflow    = ovf;
      res.entry_count = fill;
      res.stop_kind   = stop;
      res.digit_count = digits;
      res.typed_value = (stop == kce_pkg::STOP_FULL) ? '0 : value;
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(entry_result_t got);
      entry_result_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: result with no pending expectation: ",
                    "ovf=%0d cnt=%0d stop=%0d dig=%0d val=%0d"},
                   got.overflow, got.entry_count, got.stop_kind, got.digit_count,
                   got.typed_value);
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (got.overflow !== exp_res.overflow || got.entry_count !== exp_res.entry_count ||
          got.stop_kind !== exp_res.stop_kind || got.digit_count !== exp_res.digit_count ||
          got.typed_value !== exp_res.typed_value) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d expected ovf=%0d cnt=%0d stop=%0d dig=%0d val=%0d",
                   checked, exp_res.overflow, exp_res.entry_count, exp_res.stop_kind,
                   exp_res.digit_count, exp_res.typed_value);
          $display("       actual            ovf=%0d cnt=%0d stop=%0d dig=%0d val=%0d",
                   got.overflow, got.entry_count, got.stop_kind, got.digit_count,
                   got.typed_value);
        end
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_req_type;
  logic [kce_pkg::KEY_W-1:0]   in_key_code;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_overflow;
  logic [kce_pkg::COUNT_W-1:0] out_entry_count;
  logic [kce_pkg::STOP_W-1:0]  out_stop_kind;
  logic [kce_pkg::COUNT_W-1:0] out_digit_count;
  logic [kce_pkg::VALUE_W-1:0] out_typed_value;

  entry_scoreboard sb;
  bit              idle_on;
  bit              hold_req;
  int              items_sent;

  keypad_code_entry_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_key_code     (in_key_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count),
    .out_stop_kind   (out_stop_kind),
    .out_digit_count (out_digit_count),
    .out_typed_value (out_typed_value)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch both channels; every accepted transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_req_type, in_key_code);
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_overflow, out_entry_count, out_stop_kind, out_digit_count,
                       out_typed_value});
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 6);
      end
    end
  end

  // Offer one input transaction and wait until it is accepted.
  task automatic send_item(input logic req, input logic [kce_pkg::KEY_W-1:0] key);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key_code <= key;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [kce_pkg::KEY_W-1:0] rand_digit();
    int unsigned r;
    r = $urandom_range(0, 9);
    return (r == 0) ? kce_pkg::KEY_ZERO : kce_pkg::KEY_W'(r);
  endfunction

  // Codes the block ignores: no key or a code above the hash key.
  function automatic logic [kce_pkg::KEY_W-1:0] ignored_key();
    int unsigned r;
    r = $urandom_range(0, 3);
    return (r == 0) ? kce_pkg::KEY_NONE : kce_pkg::KEY_W'(int'(kce_pkg::KEY_HASH) + r);
  endfunction

  // A clear followed by digits, an optional terminator and trailing keys;
  // the trailing keys may run past the end of the buffer.
  task automatic send_entry();
    int unsigned ndig;
    int unsigned ntail;
    int unsigned used;
    send_item(kce_pkg::REQ_CLEAR, kce_pkg::KEY_W'($urandom_range(0, 15)));
    ndig = $urandom_range(0, kce_pkg::BUFFER_DEPTH);
    used = 0;
    for (int unsigned i = 0; i < ndig; i++) begin
      if ($urandom_range(19) == 0) send_item(kce_pkg::REQ_KEY, ignored_key());
      send_item(kce_pkg::REQ_KEY, rand_digit());
      used++;
    end
    if (used < kce_pkg::BUFFER_DEPTH && $urandom_range(9) < 7) begin
      send_item(kce_pkg::REQ_KEY, $urandom_range(1) ? kce_pkg::KEY_STAR : kce_pkg::KEY_HASH);
      used++;
    end
    ntail = $urandom_range(0, kce_pkg::BUFFER_DEPTH + 1 - used);
    for (int unsigned i = 0; i < ntail; i++)
      send_item(kce_pkg::REQ_KEY, kce_pkg::KEY_W'($urandom_range(1, 12)));
  endtask

  // Stimulus and end of run.
  initial begin
    int unsigned rand_start;
    bit          hold_done;
    bit          pause_done;
    sb          = new();
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    items_sent  = 0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= kce_pkg::REQ_KEY;
    in_key_code <= kce_pkg::KEY_NONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored codes, digits with a star, keys after a terminator.
    send_item(kce_pkg::REQ_KEY, kce_pkg::KEY_NONE);
    send_item(kce_pkg::REQ_KEY, 4'd15);
    send_item(kce_pkg::REQ_KEY, 4'd13);
    send_item(kce_pkg::REQ_KEY, 4'd9);
    send_item(kce_pkg::REQ_KEY, 4'd1);
    send_item(kce_pkg::REQ_KEY, kce_pkg::KEY_ZERO);
    send_item(kce_pkg::REQ_KEY, kce_pkg::KEY_STAR);
    send_item(kce_pkg::REQ_KEY, 4'd5);
    send_item(kce_pkg::REQ_KEY, kce_pkg::KEY_HASH);
    // Clear with a junk key code, then a terminator with no digit before it.
    send_item(kce_pkg::REQ_CLEAR, 4'd15);
    send_item(kce_pkg::REQ_KEY, kce_pkg::KEY_HASH);
    send_item(kce_pkg::REQ_CLEAR, kce_pkg::KEY_NONE);
    // Nine nines give the largest value, the tenth digit fills the buffer,
    // and one more key overflows it.
    for (int i = 0; i < 10; i++) send_item(kce_pkg::REQ_KEY, 4'd9);
    send_item(kce_pkg::REQ_KEY, 4'd8);
    send_item(kce_pkg::REQ_KEY, 4'd14);
    send_item(kce_pkg::REQ_CLEAR, 4'd10);

    // Random: mostly well-formed entries, the rest noise.
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        send_entry();
      end else begin
        send_item(($urandom_range(9) == 0) ? kce_pkg::REQ_CLEAR : kce_pkg::REQ_KEY,
                  kce_pkg::KEY_W'($urandom_range(0, 15)));
      end
      if (!hold_done && items_sent - rand_start > 500) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      idle_on = !(items_sent - rand_start > 800 && items_sent - rand_start < 1100);
      if (!pause_done && items_sent - rand_start > 1300) begin
        pause_done = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d input transactions and checked %0d results, %0d mismatches.",
             items_sent, sb.checked, sb.errors);
    $display("Saw %0d overflows, %0d entries full of digits, %0d star and %0d hash stops.",
             sb.overflows, sb.full_entries, sb.star_stops, sb.hash_stops);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still pending.", sb.pending());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== keypad_code_entry_core.f =====
hw/rtl/kce_pkg.sv
hw/rtl/kce_in_stage.sv
hw/rtl/kce_update.sv
hw/rtl/keypad_code_entry_core.sv
tb/tb_keypad_code_entry_core.sv
